/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock, switched off while in reset.
`define SAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define SAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/sam_pkg.sv */
// ----------------------------------------------------------------------------
// sam_pkg
// Shared constants for the arc midpoint unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sam_pkg;

  // Default coordinate width in bits (Q16.16 by default).
  localparam int unsigned CoordBitsDef = 32;

  // Bits of the tuser word on the input side.
  localparam int unsigned InUserBits = 2;

endpackage

`default_nettype wire

/* rtl/svg_arc_midpoint.sv */
// ----------------------------------------------------------------------------
// svg_arc_midpoint
// Midpoint of a circular SVG arc along its drawn sweep, in signed fixed point.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   start_x, start_y, arc_radius, end_x, end_y  large_arc, sweep_flag
// m_axis    out  mid_x, mid_y                                arc_valid
//
// One item is taken in every cycle while m_axis is not stalled; the path holds
// a radix-2 square root pipeline of COORD_BITS + 1 stages followed by a
// restoring divider of 2*COORD_BITS + 6 stages.
// Reset clears only the valid bits of the stages.
// A stall on m_axis freezes every stage together; s_axis_tready is low then.
// ----------------------------------------------------------------------------
`default_nettype none

module svg_arc_midpoint
  import sam_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     s_axis_tvalid_i,
  output      logic                                     s_axis_tready_o,
  // start_x, start_y, arc_radius, end_x, end_y, zero padding
  input  wire logic [((5*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata_i,
  // large_arc, sweep_flag
  input  wire logic [InUserBits-1:0]                    s_axis_tuser_i,
  output      logic                                     m_axis_tvalid_o,
  input  wire logic                                     m_axis_tready_i,
  // mid_x, mid_y, zero padding
  output      logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata_o,
  // arc_valid
  output      logic                                     m_axis_tuser_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned CW    = C + 1;
  localparam int unsigned SW    = 2*C + 2;
  localparam int unsigned NQ    = C + 1;
  localparam int unsigned RW    = C + 4;
  localparam int unsigned KW    = C + 3;
  localparam int unsigned NW    = 2*C + 5;
  localparam int unsigned NU    = 2*C + 6;
  localparam int unsigned DW    = C + 2;
  localparam int unsigned DRW   = C + 3;
  localparam int unsigned OUT_W = ((2*C+7)/8)*8;

  // Saturate a rounded magnitude and apply its sign.
  function automatic logic [C-1:0] sat_fn(input logic [NU-1:0] q, input logic neg);
    logic [NU-1:0] lim;
    logic [NU-1:0] v;
    lim = neg ? (NU'(1) << (C-1)) : ((NU'(1) << (C-1)) - NU'(1));
    v   = (q > lim) ? lim : q;
    v   = neg ? (NU'(0) - v) : v;
    return v[C-1:0];
  endfunction

  // The whole pipeline advances unless a finished item is held at the output.
  logic en;
  logic ov_q;
  assign en              = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Stage 1: differences, sums and doubled radius magnitude.
  logic signed [C-1:0]  x1, y1, rad, x2, y2;
  logic        [C-1:0]  rmag;
  logic signed [CW-1:0] dx1_q, dy1_q, sx1_q, sy1_q;
  logic        [CW-1:0] a21_q;
  logic                 lg1_q, sf1_q, z1_q, v1_q;
  logic signed [CW-1:0] dx1_d, dy1_d;

  assign x1    = s_axis_tdata_i[C-1:0];
  assign y1    = s_axis_tdata_i[2*C-1:C];
  assign rad   = s_axis_tdata_i[3*C-1:2*C];
  assign x2    = s_axis_tdata_i[4*C-1:3*C];
  assign y2    = s_axis_tdata_i[5*C-1:4*C];
  assign rmag  = rad[C-1] ? (C'(0) - rad) : rad;
  assign dx1_d = CW'(x1) - CW'(x2);
  assign dy1_d = CW'(y1) - CW'(y2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= dx1_d;
      dy1_q <= dy1_d;
      sx1_q <= CW'(x1) + CW'(x2);
      sy1_q <= CW'(y1) + CW'(y2);
      a21_q <= {rmag, 1'b0};
      lg1_q <= s_axis_tuser_i[0];
      sf1_q <= s_axis_tuser_i[1];
      z1_q  <= (dx1_d == '0) && (dy1_d == '0);
    end
  end

  // Stage 2: squares of the chord components and of the doubled radius.
  logic        [CW-1:0] mdx, mdy;
  logic        [SW-1:0] sqx2_q, sqy2_q, rr2_q;
  logic signed [CW-1:0] dx2_q, dy2_q, sx2_q, sy2_q;
  logic        [CW-1:0] a22_q;
  logic                 lg2_q, sf2_q, z2_q, v2_q;

  assign mdx = dx1_q[CW-1] ? (CW'(0) - dx1_q) : dx1_q;
  assign mdy = dy1_q[CW-1] ? (CW'(0) - dy1_q) : dy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx2_q <= SW'(mdx) * SW'(mdx);
      sqy2_q <= SW'(mdy) * SW'(mdy);
      rr2_q  <= SW'(a21_q) * SW'(a21_q);
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
      a22_q  <= a21_q;
      lg2_q  <= lg1_q;
      sf2_q  <= sf1_q;
      z2_q   <= z1_q;
    end
  end

  // Stage 3 and square root pipeline: index 0 is loaded from the sum of squares.
  logic        [SW-1:0] srad_q  [NQ+1];
  logic        [RW-1:0] srem_q  [NQ+1];
  logic        [CW-1:0] sroot_q [NQ+1];
  logic        [SW-1:0] hrad_q  [NQ+1];
  logic        [RW-1:0] hrem_q  [NQ+1];
  logic        [CW-1:0] hroot_q [NQ+1];
  logic signed [CW-1:0] qdx_q   [NQ+1];
  logic signed [CW-1:0] qdy_q   [NQ+1];
  logic signed [CW-1:0] qsx_q   [NQ+1];
  logic signed [CW-1:0] qsy_q   [NQ+1];
  logic        [CW-1:0] qa2_q   [NQ+1];
  logic                 qge_q   [NQ+1];
  logic                 qlg_q   [NQ+1];
  logic                 qsf_q   [NQ+1];
  logic                 qz_q    [NQ+1];
  logic                 qv_q    [NQ+1];
  logic        [SW-1:0] ssum;

  assign ssum = sqx2_q + sqy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q[0] <= 1'b0;
    end else if (en) begin
      qv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      srad_q[0]  <= ssum;
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
      hrad_q[0]  <= (ssum >= rr2_q) ? '0 : (rr2_q - ssum);
      hrem_q[0]  <= '0;
      hroot_q[0] <= '0;
      qge_q[0]   <= ssum >= rr2_q;
      qdx_q[0]   <= dx2_q;
      qdy_q[0]   <= dy2_q;
      qsx_q[0]   <= sx2_q;
      qsy_q[0]   <= sy2_q;
      qa2_q[0]   <= a22_q;
      qlg_q[0]   <= lg2_q;
      qsf_q[0]   <= sf2_q;
      qz_q[0]    <= z2_q;
    end
  end

  // One root bit per stage for both the chord length and the centre offset.
  for (genvar j = 1; j <= NQ; j++) begin : g_sqrt
    logic [RW-1:0] s_remc, s_trial, h_remc, h_trial;

    assign s_remc  = {srem_q[j-1][RW-3:0], srad_q[j-1][SW-1:SW-2]};
    assign s_trial = {1'b0, sroot_q[j-1], 2'b01};
    assign h_remc  = {hrem_q[j-1][RW-3:0], hrad_q[j-1][SW-1:SW-2]};
    assign h_trial = {1'b0, hroot_q[j-1], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qv_q[j] <= 1'b0;
      end else if (en) begin
        qv_q[j] <= qv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        srad_q[j] <= srad_q[j-1] << 2;
        hrad_q[j] <= hrad_q[j-1] << 2;
        if (s_remc >= s_trial) begin
          srem_q[j]  <= s_remc - s_trial;
          sroot_q[j] <= {sroot_q[j-1][CW-2:0], 1'b1};
        end else begin
          srem_q[j]  <= s_remc;
          sroot_q[j] <= {sroot_q[j-1][CW-2:0], 1'b0};
        end
        if (h_remc >= h_trial) begin
          hrem_q[j]  <= h_remc - h_trial;
          hroot_q[j] <= {hroot_q[j-1][CW-2:0], 1'b1};
        end else begin
          hrem_q[j]  <= h_remc;
          hroot_q[j] <= {hroot_q[j-1][CW-2:0], 1'b0};
        end
        qge_q[j] <= qge_q[j-1];
        qdx_q[j] <= qdx_q[j-1];
        qdy_q[j] <= qdy_q[j-1];
        qsx_q[j] <= qsx_q[j-1];
        qsy_q[j] <= qsy_q[j-1];
        qa2_q[j] <= qa2_q[j-1];
        qlg_q[j] <= qlg_q[j-1];
        qsf_q[j] <= qsf_q[j-1];
        qz_q[j]  <= qz_q[j-1];
      end
    end
  end

  // Stage K: signed offset along the normal from the flags.
  logic        [CW-1:0] len_n, r2k;
  logic signed [KW-1:0] tk;
  logic signed [KW-1:0] kk_q;
  logic        [CW-1:0] lenk_q;
  logic signed [CW-1:0] dxk_q, dyk_q, sxk_q, syk_q;
  logic                 zk_q, vk_q;

  assign len_n = sroot_q[NQ];
  assign r2k   = qge_q[NQ] ? len_n : qa2_q[NQ];
  assign tk    = qlg_q[NQ] ? (KW'(hroot_q[NQ]) + KW'(r2k))
                           : (KW'(hroot_q[NQ]) - KW'(r2k));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q <= 1'b0;
    end else if (en) begin
      vk_q <= qv_q[NQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kk_q   <= (qlg_q[NQ] == qsf_q[NQ]) ? tk : (KW'(0) - tk);
      lenk_q <= len_n;
      dxk_q  <= qdx_q[NQ];
      dyk_q  <= qdy_q[NQ];
      sxk_q  <= qsx_q[NQ];
      syk_q  <= qsy_q[NQ];
      zk_q   <= qz_q[NQ];
    end
  end

  // Stage M: the four products of the numerators.
  logic signed [C+1:0]   lens;
  logic signed [2*C+2:0] p1_q, p3_q;
  logic signed [2*C+3:0] p2_q, p4_q;
  logic        [CW-1:0]  lenm_q;
  logic                  zm_q, vm_q;

  assign lens = $signed({1'b0, lenk_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= vk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= (2*C+3)'(sxk_q) * (2*C+3)'(lens);
      p3_q   <= (2*C+3)'(syk_q) * (2*C+3)'(lens);
      p2_q   <= (2*C+4)'(kk_q) * (2*C+4)'(dyk_q);
      p4_q   <= (2*C+4)'(kk_q) * (2*C+4)'(dxk_q);
      lenm_q <= lenk_q;
      zm_q   <= zk_q;
    end
  end

  // Stage N: numerator sums.
  logic signed [NW-1:0] nx_q, ny_q;
  logic        [CW-1:0] lenn_q;
  logic                 zn_q, vn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (en) begin
      vn_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= NW'(p1_q) - NW'(p2_q);
      ny_q   <= NW'(p3_q) + NW'(p4_q);
      lenn_q <= lenm_q;
      zn_q   <= zm_q;
    end
  end

  // Stage O and divider: index 0 holds magnitude plus half divisor.
  logic [NU-1:0]  xnum_q [NU+1];
  logic [NU-1:0]  ynum_q [NU+1];
  logic [NU-1:0]  xq_q   [NU+1];
  logic [NU-1:0]  yq_q   [NU+1];
  logic [DRW-1:0] xrem_q [NU+1];
  logic [DRW-1:0] yrem_q [NU+1];
  logic [DW-1:0]  dd_q   [NU+1];
  logic           xneg_q [NU+1];
  logic           yneg_q [NU+1];
  logic           dz_q   [NU+1];
  logic           dv_q   [NU+1];
  logic [NU-1:0]  xmag, ymag;

  assign xmag = nx_q[NW-1] ? (NU'(0) - NU'(nx_q)) : NU'(nx_q);
  assign ymag = ny_q[NW-1] ? (NU'(0) - NU'(ny_q)) : NU'(ny_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= vn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xnum_q[0] <= xmag + NU'(lenn_q);
      ynum_q[0] <= ymag + NU'(lenn_q);
      xq_q[0]   <= '0;
      yq_q[0]   <= '0;
      xrem_q[0] <= '0;
      yrem_q[0] <= '0;
      dd_q[0]   <= {lenn_q, 1'b0};
      xneg_q[0] <= nx_q[NW-1];
      yneg_q[0] <= ny_q[NW-1];
      dz_q[0]   <= zn_q;
    end
  end

  // One quotient bit per stage for both coordinates.
  for (genvar j = 1; j <= NU; j++) begin : g_div
    logic [DRW-1:0] x_remc, y_remc, dext;

    assign x_remc = {xrem_q[j-1][DRW-2:0], xnum_q[j-1][NU-1]};
    assign y_remc = {yrem_q[j-1][DRW-2:0], ynum_q[j-1][NU-1]};
    assign dext   = {1'b0, dd_q[j-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en) begin
        dv_q[j] <= dv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        xnum_q[j] <= xnum_q[j-1] << 1;
        ynum_q[j] <= ynum_q[j-1] << 1;
        if (x_remc >= dext) begin
          xrem_q[j] <= x_remc - dext;
          xq_q[j]   <= {xq_q[j-1][NU-2:0], 1'b1};
        end else begin
          xrem_q[j] <= x_remc;
          xq_q[j]   <= {xq_q[j-1][NU-2:0], 1'b0};
        end
        if (y_remc >= dext) begin
          yrem_q[j] <= y_remc - dext;
          yq_q[j]   <= {yq_q[j-1][NU-2:0], 1'b1};
        end else begin
          yrem_q[j] <= y_remc;
          yq_q[j]   <= {yq_q[j-1][NU-2:0], 1'b0};
        end
        dd_q[j]   <= dd_q[j-1];
        xneg_q[j] <= xneg_q[j-1];
        yneg_q[j] <= yneg_q[j-1];
        dz_q[j]   <= dz_q[j-1];
      end
    end
  end

  // Output register: saturation, and zeros when the endpoints coincide.
  logic [C-1:0] ox_q, oy_q;
  logic         oa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv_q[NU];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q <= dz_q[NU] ? '0 : sat_fn(xq_q[NU], xneg_q[NU]);
      oy_q <= dz_q[NU] ? '0 : sat_fn(yq_q[NU], yneg_q[NU]);
      oa_q <= !dz_q[NU];
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = OUT_W'({oy_q, ox_q});
  assign m_axis_tuser_o  = oa_q;

  // Checks on the result path.
`include "assert_macros.svh"
  `SAM_ASSERT(a_zero_data, (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0), "no-arc item carries nonzero data")
  `SAM_ASSERT(a_zero_flag, (en && dv_q[NU] && dz_q[NU]) |=> (m_axis_tvalid_o && !m_axis_tuser_o), "coincident endpoints not flagged")
  `SAM_ASSERT(a_stall_hold, (ov_q && !m_axis_tready_i) |=> (ov_q && $stable(ox_q) && $stable(oy_q)), "stalled result changed")
  `SAM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "result valid during reset")

endmodule

`default_nettype wire

/* tb/svg_arc_midpoint_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svg_arc_midpoint_tb
// Drives circular arcs into the midpoint unit and checks every result item
// against a bit-exact predictor or a hand-worked midpoint, with random idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module svg_arc_midpoint_tb;
  import sam_pkg::*;

  localparam int unsigned CB = CoordBitsDef;
  localparam int unsigned InBits = ((5*CB+7)/8)*8;
  localparam int unsigned OutBits = ((2*CB+7)/8)*8;
  localparam int unsigned Latency = 3*CB + 15;
  localparam int unsigned NumRandom = 1030;
  localparam longint CycleLimit = 400000;
  localparam logic [CB-1:0] MaxPos = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] MaxNeg = {1'b1, {(CB-1){1'b0}}};

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    coord_t sx, sy, rad;
    logic   large_arc, sweep;
    coord_t ex, ey;
  } arc_t;

  typedef struct packed {
    coord_t mx, my;
    logic   ok;
  } mid_t;

  // Directed row: an arc, and optionally a hand-worked midpoint.
  typedef struct packed {
    arc_t arc;
    logic typed;
    mid_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [InBits-1:0] s_data = '0;
  logic [InUserBits-1:0] s_user = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OutBits-1:0] m_data;
  logic m_user;

  mid_t   pending_mids[$];
  int     errors = 0;
  int     results_seen = 0;
  int     invalid_seen = 0;
  longint cycles = 0;
  logic   no_idle = 1'b0;

  always #5 clk_i = ~clk_i;

  svg_arc_midpoint i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  // Integer square root, rounded down.
  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] root;
    logic [127:0] cand;
    root = '0;
    for (int i = 40; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  // Divide by twice the chord, round half away from zero, then saturate.
  function automatic coord_t round_sat(logic signed [127:0] num, logic [127:0] len);
    logic         neg;
    logic [127:0] mag;
    logic [127:0] q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag + len) / (len << 1);
    if (neg) begin
      if (q > {1'b0, MaxNeg}) return MaxNeg;
      return coord_t'(-q);
    end
    if (q > {1'b0, MaxPos}) return MaxPos;
    return coord_t'(q);
  endfunction

  // Midpoint of the drawn sweep.
  function automatic mid_t arc_midpoint(arc_t a);
    logic signed [127:0] x1, y1, x2, y2, dx, dy, rmag, s, rr4;
    logic signed [127:0] len, r2, h2, t, k;
    mid_t m;
    x1 = $signed(a.sx); y1 = $signed(a.sy);
    x2 = $signed(a.ex); y2 = $signed(a.ey);
    rmag = $signed(a.rad);
    if (rmag < 0) rmag = -rmag;
    dx = x1 - x2;
    dy = y1 - y2;
    m = '0;
    if (dx == 0 && dy == 0) return m;
    s = dx * dx + dy * dy;
    rr4 = 4 * rmag * rmag;
    len = isqrt(s);
    if (s >= rr4) begin
      r2 = len;
      h2 = 0;
    end else begin
      r2 = 2 * rmag;
      h2 = isqrt(rr4 - s);
    end
    t = a.large_arc ? h2 + r2 : h2 - r2;
    k = (a.large_arc == a.sweep) ? t : -t;
    m.mx = round_sat((x1 + x2) * len - k * dy, len);
    m.my = round_sat((y1 + y2) * len + k * dx, len);
    m.ok = 1'b1;
    return m;
  endfunction

  task automatic report(string what, mid_t got, mid_t want);
    errors++;
    $display("MISMATCH %s: got x=%h y=%h ok=%b, want x=%h y=%h ok=%b", what,
             got.mx, got.my, got.ok, want.mx, want.my, want.ok);
  endtask

  // Sends one arc after a random gap and records its expected midpoint.
  task automatic send_arc(arc_t a, logic typed, mid_t res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(6);
    repeat (gap) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= InBits'({a.ey, a.ex, a.rad, a.sy, a.sx});
    s_user  <= {a.sweep, a.large_arc};
    do @(posedge clk_i); while (!s_ready);
    pending_mids.insert(pending_mids.size(), typed ? res : arc_midpoint(a));
    @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
      1: return coord_t'($urandom);
      default: return ($urandom_range(1)) ? MaxPos : MaxNeg;
    endcase
  endfunction

  // Result side: random stalls, then compare with the oldest expectation.
  initial begin
    mid_t got;
    int   gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = no_idle ? 0 : $urandom_range(6);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
      got.mx = m_data[CB-1:0];
      got.my = m_data[2*CB-1:CB];
      got.ok = m_user;
      results_seen++;
      if (!got.ok) invalid_seen++;
      if (pending_mids.size() == 0) begin
        report("unexpected item", got, '0);
      end else if (got != pending_mids[0]) begin
        report("midpoint", got, pending_mids.pop_front());
      end else begin
        void'(pending_mids.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("svg_arc_midpoint test failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    arc_t a;
    int   mode;
    int   n;
    // Equal endpoints give no arc, whatever the radius and flags.
    rows.insert(rows.size(),
                row_t'{'{32'h0, 32'h0, 32'h10000, 1'b0, 1'b0, 32'h0, 32'h0}, 1'b1, '0});
    rows.insert(rows.size(),
                row_t'{'{MaxPos, MaxNeg, MaxNeg, 1'b1, 1'b1, MaxPos, MaxNeg}, 1'b1, '0});
    rows.insert(rows.size(),
                row_t'{'{MaxNeg, MaxPos, 32'h0, 1'b1, 1'b0, MaxNeg, MaxPos}, 1'b1, '0});
    // Half circle of radius one over a chord of two.
    rows.insert(rows.size(),
                row_t'{'{32'h0, 32'h0, 32'h10000, 1'b0, 1'b1, 32'h20000, 32'h0}, 1'b1,
                       '{32'h10000, 32'hFFFF0000, 1'b1}});
    // All flag combinations on a generous radius.
    for (int f = 0; f < 4; f++)
      rows.insert(rows.size(),
                  row_t'{'{32'h10000, 32'h30000, 32'h50000, f[1], f[0], 32'h40000,
                           32'hFFFE0000}, 1'b0, '0});
    // Zero and negative radii, too-small radius, and a half circle's large flag.
    rows.insert(rows.size(),
                row_t'{'{32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0, 32'h30000}, 1'b0, '0});
    rows.insert(rows.size(),
                row_t'{'{32'h0, 32'h0, 32'hFFFB0000, 1'b0, 1'b1, 32'h30000, 32'h40000},
                       1'b0, '0});
    rows.insert(rows.size(),
                row_t'{'{32'h0, 32'h0, 32'h8000, 1'b1, 1'b1, 32'h30000, 32'h40000},
                       1'b0, '0});
    rows.insert(rows.size(),
                row_t'{'{32'h0, 32'h0, 32'h28000, 1'b1, 1'b0, 32'h30000, 32'h40000},
                       1'b0, '0});
    // Extremes that push the midpoint into saturation.
    rows.insert(rows.size(),
                row_t'{'{MaxPos, MaxPos, MaxPos, 1'b1, 1'b1, MaxNeg, MaxNeg}, 1'b0, '0});
    rows.insert(rows.size(),
                row_t'{'{MaxNeg, MaxNeg, MaxNeg, 1'b1, 1'b0, MaxPos, MaxPos}, 1'b0, '0});
    rows.insert(rows.size(),
                row_t'{'{MaxPos, MaxPos, MaxNeg, 1'b1, 1'b0, MaxPos, MaxPos - 1}, 1'b0, '0});
    rows.insert(rows.size(),
                row_t'{'{MaxNeg, MaxNeg, MaxPos, 1'b1, 1'b1, MaxNeg + 1, MaxNeg}, 1'b0, '0});
    rows.insert(rows.size(),
                row_t'{'{MaxPos, MaxNeg, 32'h1, 1'b0, 1'b0, MaxNeg, MaxPos}, 1'b0, '0});
    rows.insert(rows.size(),
                row_t'{'{32'h1, 32'h0, 32'h1, 1'b0, 1'b1, 32'h0, 32'h1}, 1'b0, '0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_arc(rows[i].arc, rows[i].typed, rows[i].res);

    // Random arcs: mostly moderate geometry, some full range and extremes.
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 200 == 0) no_idle = (i % 400 == 200);
      n = $urandom_range(99);
      mode = (n < 60) ? 0 : (n < 92) ? 1 : 2;
      a.sx = rand_coord(mode);
      a.sy = rand_coord(mode);
      a.ex = rand_coord($urandom_range(9) == 0 ? 2 : mode);
      a.ey = rand_coord(mode);
      a.large_arc = 1'($urandom_range(1));
      a.sweep = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: begin
          a.ex = a.sx;
          a.ey = a.sy;
          a.rad = rand_coord(mode);
        end
        1, 2: a.rad = coord_t'($signed(a.ex - a.sx) >>> 1);
        3: a.rad = coord_t'($urandom_range(16));
        default: a.rad = rand_coord(mode);
      endcase
      send_arc(a, 1'b0, '0);
    end
    s_valid <= 1'b0;

    while (pending_mids.size() != 0) @(posedge clk_i);
    repeat (Latency + 40) @(posedge clk_i);
    $display("Sent %0d directed and %0d random arcs; %0d results checked, %0d without arc.",
             rows.size(), NumRandom, results_seen, invalid_seen);
    if (errors == 0) begin
      $display("svg_arc_midpoint test passed");
    end else begin
      $display("svg_arc_midpoint test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/sam_pkg.sv
rtl/svg_arc_midpoint.sv
tb/svg_arc_midpoint_tb.sv
